// ===== rtl/key_matrix_debouncer_macros.svh =====
// Assertion helpers for the debouncer RTL.
`ifndef KEY_MATRIX_DEBOUNCER_MACROS_SVH
`define KEY_MATRIX_DEBOUNCER_MACROS_SVH

// Condition and consequence in the same cycle.
`define KMD_CHECK_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequence in the cycle after the condition.
`define KMD_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/kmd_pkg.sv =====
package kmd_pkg;

   localparam int ROW_COUNT_DEF = 8;
   localparam int COL_COUNT_DEF = 8;

   localparam int ROW_W  = 3;
   localparam int COL_W  = 3;
   localparam int TIME_W = 32;
   localparam int DEB_W  = 8;

   localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 8'd15;

   // one scanned sample as it travels down the pipeline
   typedef struct packed {
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic              level;
      logic [TIME_W-1:0] time_ms;
      logic              in_range;
   } item_type;

   typedef struct packed {
      logic down;
      logic pending;
   } flags_type;

   typedef struct packed {
      flags_type         flags;
      logic [TIME_W-1:0] change_time;
   } state_type;

   // write strobes of the per-key store
   typedef struct packed {
      logic flag_we;
      logic time_we;
   } wr_ctl_type;

   typedef struct packed {
      logic             valid;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             pressed;
   } event_type;

   localparam int FLAGS_W = $bits(flags_type);

endpackage

// ===== rtl/kmd_ram.sv =====
module kmd_ram
   #(
      parameter int WIDTH = 8,
      parameter int DEPTH = 64,
      localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
   )
   (
      input  logic              clock,
      input  logic              wr_en,
      input  logic [ADDR_W-1:0] wr_addr,
      input  logic [WIDTH-1:0]  wr_data,
      input  logic              rd_en,
      input  logic [ADDR_W-1:0] rd_addr,
      output logic [WIDTH-1:0]  rd_data
   );

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port (read returns old data on collision)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/kmd_fetch.sv =====
module kmd_fetch
   import kmd_pkg::*;
   #(
      parameter int KEY_W = 6
   )
   (
      input  logic              clock,
      input  logic              reset,
      input  logic              advance,
      input  logic              accept,
      input  item_type          req_item,
      input  logic [KEY_W-1:0]  req_key,
      input  flags_type         ram_flags,
      input  logic [TIME_W-1:0] ram_time,
      input  wr_ctl_type        wr_ctl,
      input  logic [KEY_W-1:0]  wr_key,
      input  state_type         wr_state,
      output logic              s2_valid,
      output item_type          s2_item,
      output logic [KEY_W-1:0]  s2_key,
      output state_type         s2_state
   );

   logic             s1_valid_ff;
   item_type         s1_item_ff;
   logic [KEY_W-1:0] s1_key_ff;
   logic             last_we_ff;
   logic [KEY_W-1:0] last_key_ff;
   state_type        last_state_ff;
   logic             s2_valid_ff;
   item_type         s2_item_ff;
   logic [KEY_W-1:0] s2_key_ff;
   state_type        s2_state_ff;
   state_type        s2_state_in;

   // patch the memory word with the writes its read could not see
   always_comb begin
      priority if (wr_ctl.flag_we && (wr_key == s1_key_ff)) begin
         s2_state_in = wr_state;
      end else if (last_we_ff && (last_key_ff == s1_key_ff)) begin
         s2_state_in = last_state_ff;
      end else begin
         s2_state_in = '{flags: ram_flags, change_time: ram_time};
      end
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         last_we_ff  <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         last_we_ff  <= wr_ctl.flag_we;
      end
   end

   // advance payload and remember the write of this edge
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_item_ff    <= req_item;
         s1_key_ff     <= req_key;
         s2_item_ff    <= s1_item_ff;
         s2_key_ff     <= s1_key_ff;
         s2_state_ff   <= s2_state_in;
         last_key_ff   <= wr_key;
         last_state_ff <= wr_state;
      end
   end

   assign s2_valid = s2_valid_ff;
   assign s2_item  = s2_item_ff;
   assign s2_key   = s2_key_ff;
   assign s2_state = s2_state_ff;

endmodule

// ===== rtl/kmd_decide.sv =====
module kmd_decide
   import kmd_pkg::*;
   #(
      parameter int KEY_W = 6
   )
   (
      input  logic              clock,
      input  logic              reset,
      input  logic              advance,
      input  logic [DEB_W-1:0]  debounce,
      input  logic              s2_valid,
      input  item_type          s2_item,
      input  logic [KEY_W-1:0]  s2_key,
      input  state_type         s2_state,
      output wr_ctl_type        wr_ctl,
      output logic [KEY_W-1:0]  wr_key,
      output state_type         wr_state,
      output event_type         evt
   );

   logic              s3_valid_ff;
   item_type          s3_item_ff;
   logic [KEY_W-1:0]  s3_key_ff;
   state_type         s3_state_ff;
   state_type         s3_state_in;
   logic              differs;
   logic              qualified;
   logic              start;
   logic              expired;
   logic [TIME_W-1:0] elapsed;

   // take the update of the item leaving this stage on the same edge
   assign s3_state_in = (wr_ctl.flag_we && (wr_key == s2_key)) ? wr_state : s2_state;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_item_ff  <= s2_item;
         s3_key_ff   <= s2_key;
         s3_state_ff <= s3_state_in;
      end
   end

   // level 0 is closed, so a sample differs when level equals the down flag
   assign differs   = (s3_item_ff.level == s3_state_ff.flags.down);
   assign qualified = s3_valid_ff && s3_item_ff.in_range && differs;
   assign elapsed   = s3_item_ff.time_ms - s3_state_ff.change_time;
   assign start     = qualified && !s3_state_ff.flags.pending;
   assign expired   = qualified && s3_state_ff.flags.pending &&
                      (elapsed > {{(TIME_W-DEB_W){1'b0}}, debounce});

   // write back: arm the timer, or toggle and clear pending
   always_comb begin
      wr_ctl.flag_we = advance && (start || expired);
      wr_ctl.time_we = advance && start;
      wr_key         = s3_key_ff;
      if (start) begin
         wr_state.flags.down    = s3_state_ff.flags.down;
         wr_state.flags.pending = 1'b1;
         wr_state.change_time   = s3_item_ff.time_ms;
      end else begin
         wr_state.flags.down    = !s3_state_ff.flags.down;
         wr_state.flags.pending = 1'b0;
         wr_state.change_time   = s3_state_ff.change_time;
      end
   end

   // press or release event
   always_comb begin
      evt.valid   = expired;
      evt.row     = s3_item_ff.row;
      evt.col     = s3_item_ff.col;
      evt.pressed = !s3_state_ff.flags.down;
   end

endmodule

// ===== rtl/kmd_out.sv =====
module kmd_out
   import kmd_pkg::*;
   (
      input  logic             clock,
      input  logic             reset,
      input  logic             advance,
      input  event_type        evt,
      input  logic             rsp_ready,
      output logic             rsp_valid,
      output logic [ROW_W-1:0] rsp_event_row,
      output logic [COL_W-1:0] rsp_event_col,
      output logic             rsp_pressed,
      output logic             skid_full
   );

   event_type rsp_ff;
   event_type skid_ff;
   logic      rsp_free;
   logic      take_new;

   assign rsp_free = !rsp_ff.valid || rsp_ready;
   assign take_new = advance && evt.valid;

   // output register with one skid entry behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff.valid  <= 1'b0;
         skid_ff.valid <= 1'b0;
      end else if (rsp_free) begin
         rsp_ff.valid  <= skid_ff.valid || take_new;
         skid_ff.valid <= 1'b0;
      end else if (take_new) begin
         skid_ff.valid <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_free) begin
         if (skid_ff.valid) begin
            rsp_ff.row     <= skid_ff.row;
            rsp_ff.col     <= skid_ff.col;
            rsp_ff.pressed <= skid_ff.pressed;
         end else begin
            rsp_ff.row     <= evt.row;
            rsp_ff.col     <= evt.col;
            rsp_ff.pressed <= evt.pressed;
         end
      end else if (take_new) begin
         skid_ff.row     <= evt.row;
         skid_ff.col     <= evt.col;
         skid_ff.pressed <= evt.pressed;
      end
   end

   assign rsp_valid     = rsp_ff.valid;
   assign rsp_event_row = rsp_ff.row;
   assign rsp_event_col = rsp_ff.col;
   assign rsp_pressed   = rsp_ff.pressed;
   assign skid_full     = skid_ff.valid;

endmodule

// ===== rtl/key_matrix_debouncer.sv =====
// A sample's event passes the s1, s2 and s3 stage registers, then the output register, to rsp_*.
// Throughput: one sample per cycle while req_ready is high; per-key read-modify-write is bypassed across stages.
// A waiting event plus one in the skid entry stalls the three-stage pipeline.
// Reset: synchronous; the debounce delay returns to 15 and a clearing pass walks every
// entry of the flag memory, during which req_ready stays low.
`include "key_matrix_debouncer_macros.svh"

module key_matrix_debouncer
   import kmd_pkg::*;
   #(
      parameter int ROW_COUNT = ROW_COUNT_DEF,
      parameter int COL_COUNT = COL_COUNT_DEF
   )
   (
      input  logic              clock,
      input  logic              reset,
      input  logic              csr_write_en,
      input  logic [DEB_W-1:0]  csr_write_data,
      input  logic              req_valid,
      output logic              req_ready,
      input  logic [ROW_W-1:0]  req_row,
      input  logic [COL_W-1:0]  req_col,
      input  logic              req_level,
      input  logic [TIME_W-1:0] req_time_ms,
      output logic              rsp_valid,
      input  logic              rsp_ready,
      output logic [ROW_W-1:0]  rsp_event_row,
      output logic [COL_W-1:0]  rsp_event_col,
      output logic              rsp_pressed
   );

   localparam int KEY_TOTAL = ROW_COUNT * COL_COUNT;
   localparam int KEY_W     = (KEY_TOTAL > 1) ? $clog2(KEY_TOTAL) : 1;

   logic [DEB_W-1:0]  debounce_ff;
   logic              clearing_ff;
   logic [KEY_W-1:0]  clr_ptr_ff;
   logic              advance;
   logic              accept;
   logic              skid_full;
   item_type          req_item;
   logic [KEY_W-1:0]  req_key;
   flags_type         ram_flags;
   logic [TIME_W-1:0] ram_time;
   wr_ctl_type        wr_ctl;
   logic [KEY_W-1:0]  wr_key;
   state_type         wr_state;
   logic              s2_valid;
   item_type          s2_item;
   logic [KEY_W-1:0]  s2_key;
   state_type         s2_state;
   event_type         evt;
   logic              flag_wr_en;
   logic [KEY_W-1:0]  flag_wr_addr;
   flags_type         flag_wr_data;

   // debounce delay register
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
      end else if (csr_write_en) begin
         debounce_ff <= csr_write_data;
      end
   end

   // sweep the flag memory after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_ptr_ff  <= '0;
      end else if (clearing_ff) begin
         clr_ptr_ff <= clr_ptr_ff + 1'b1;
         if (clr_ptr_ff == KEY_W'(KEY_TOTAL - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // pipeline moves while the skid entry is free
   assign advance   = !skid_full;
   assign req_ready = advance && !clearing_ff;
   assign accept    = req_valid && req_ready;

   // key address and range check
   always_comb begin
      req_item.row      = req_row;
      req_item.col      = req_col;
      req_item.level    = req_level;
      req_item.time_ms  = req_time_ms;
      req_item.in_range = (int'(req_row) < ROW_COUNT) && (int'(req_col) < COL_COUNT);
      req_key           = KEY_W'(int'(req_row) * COL_COUNT + int'(req_col));
   end

   // flag memory write: clearing pass or pipeline write-back
   assign flag_wr_en   = clearing_ff || wr_ctl.flag_we;
   assign flag_wr_addr = clearing_ff ? clr_ptr_ff : wr_key;
   assign flag_wr_data = clearing_ff ? '0 : wr_state.flags;

   kmd_ram #(
      .WIDTH (FLAGS_W),
      .DEPTH (KEY_TOTAL)
   ) u_flag_ram (
      .clock   (clock),
      .wr_en   (flag_wr_en),
      .wr_addr (flag_wr_addr),
      .wr_data (flag_wr_data),
      .rd_en   (advance),
      .rd_addr (req_key),
      .rd_data (ram_flags)
   );

   kmd_ram #(
      .WIDTH (TIME_W),
      .DEPTH (KEY_TOTAL)
   ) u_time_ram (
      .clock   (clock),
      .wr_en   (wr_ctl.time_we),
      .wr_addr (wr_key),
      .wr_data (wr_state.change_time),
      .rd_en   (advance),
      .rd_addr (req_key),
      .rd_data (ram_time)
   );

   kmd_fetch #(
      .KEY_W (KEY_W)
   ) u_fetch (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .accept    (accept),
      .req_item  (req_item),
      .req_key   (req_key),
      .ram_flags (ram_flags),
      .ram_time  (ram_time),
      .wr_ctl    (wr_ctl),
      .wr_key    (wr_key),
      .wr_state  (wr_state),
      .s2_valid  (s2_valid),
      .s2_item   (s2_item),
      .s2_key    (s2_key),
      .s2_state  (s2_state)
   );

   kmd_decide #(
      .KEY_W (KEY_W)
   ) u_decide (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .debounce (debounce_ff),
      .s2_valid (s2_valid),
      .s2_item  (s2_item),
      .s2_key   (s2_key),
      .s2_state (s2_state),
      .wr_ctl   (wr_ctl),
      .wr_key   (wr_key),
      .wr_state (wr_state),
      .evt      (evt)
   );

   kmd_out u_out (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .evt           (evt),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .rsp_event_row (rsp_event_row),
      .rsp_event_col (rsp_event_col),
      .rsp_pressed   (rsp_pressed),
      .skid_full     (skid_full)
   );

   // checks
   `KMD_CHECK_NOW(a_skid_behind_rsp, skid_full, rsp_valid, "skid holds an event but rsp is empty")
   `KMD_CHECK_NEXT(a_event_lands, advance && evt.valid, rsp_valid, "event lost on the way out")
   `KMD_CHECK_NOW(a_quiet_while_clearing, clearing_ff, !wr_ctl.flag_we && !wr_ctl.time_we, "write-back during clearing pass")

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import kmd_pkg::*;

   localparam int KEY_TOTAL     = 64;
   localparam int SETTLE_CYCLES = 8;
   localparam int STALL_LIMIT   = 5000;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             pressed;
   } key_event_t;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_write_en = 1'b0;
   logic [DEB_W-1:0]  csr_write_data = '0;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [ROW_W-1:0]  req_row = '0;
   logic [COL_W-1:0]  req_col = '0;
   logic              req_level = 1'b1;
   logic [TIME_W-1:0] req_time_ms = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [ROW_W-1:0]  rsp_event_row;
   logic [COL_W-1:0]  rsp_event_col;
   logic              rsp_pressed;

   // debounce state mirrored per key
   logic              key_down_q [KEY_TOTAL];
   logic              pending_q [KEY_TOTAL];
   logic [TIME_W-1:0] first_seen_q [KEY_TOTAL];
   logic [DEB_W-1:0]  delay_q;

   key_event_t expected_events [$];
   int         error_count = 0;
   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;
   int         quiet_cycles = 0;

   key_matrix_debouncer dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_row        (req_row),
      .req_col        (req_col),
      .req_level      (req_level),
      .req_time_ms    (req_time_ms),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_row  (rsp_event_row),
      .rsp_event_col  (rsp_event_col),
      .rsp_pressed    (rsp_pressed)
   );

   always #4 clock = ~clock;

   // Advance the debounce state by one sample; return 1 when the key toggles.
   function automatic bit predict_debounce(input logic [ROW_W-1:0] row,
                                           input logic [COL_W-1:0] col,
                                           input logic level,
                                           input logic [TIME_W-1:0] stamp,
                                           output key_event_t ev);
      int                k;
      logic [TIME_W-1:0] elapsed;
      k  = {row, col};
      ev = '0;
      // level 0 is closed: it differs from the state when it equals key_down
      if (level != key_down_q[k]) return 1'b0;
      if (!pending_q[k]) begin
         pending_q[k]    = 1'b1;
         first_seen_q[k] = stamp;
         return 1'b0;
      end
      elapsed = stamp - first_seen_q[k];
      if (elapsed > TIME_W'(delay_q)) begin
         key_down_q[k] = ~key_down_q[k];
         pending_q[k]  = 1'b0;
         ev.row        = row;
         ev.col        = col;
         ev.pressed    = key_down_q[k];
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t mismatch: %s", $realtime, what);
      error_count++;
   endtask

   // Offer one sample, hold it until the transfer, then record its expected event.
   task automatic send_sample(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
                              input logic level, input logic [TIME_W-1:0] stamp);
      key_event_t ev;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_row     <= row;
      req_col     <= col;
      req_level   <= level;
      req_time_ms <= stamp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (predict_debounce(row, col, level, stamp, ev)) expected_events.push_back(ev);
   endtask

   // Drop valid and wait until every expected event has come and the pipe is empty.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_debounce(input logic [DEB_W-1:0] value);
      drain_pipeline();
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      delay_q = value;
   endtask

   task automatic apply_reset();
      foreach (key_down_q[i]) begin
         key_down_q[i]   = 1'b0;
         pending_q[i]    = 1'b0;
         first_seen_q[i] = '0;
      end
      delay_q = DEBOUNCE_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      // hold off until the clearing pass is over
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Reset delay: 15 ms is not enough, 16 ms toggles; press then release.
   task automatic test_default_delay();
      send_sample(3'd0, 3'd0, 1'b0, 32'd1000);
      send_sample(3'd0, 3'd0, 1'b0, 32'd1015);
      send_sample(3'd0, 3'd0, 1'b0, 32'd1016);
      send_sample(3'd0, 3'd0, 1'b1, 32'd2000);
      send_sample(3'd0, 3'd0, 1'b1, 32'd2016);
   endtask

   // A level that agrees again does not cancel the pending change.
   task automatic test_pending_kept();
      send_sample(3'd7, 3'd7, 1'b0, 32'd500);
      send_sample(3'd7, 3'd7, 1'b1, 32'd505);
      send_sample(3'd7, 3'd7, 1'b0, 32'd520);
   endtask

   // Zero delay: the first differing sample only starts the timer.
   task automatic test_zero_delay();
      write_debounce(8'd0);
      send_sample(3'd3, 3'd5, 1'b0, 32'd10);
      send_sample(3'd3, 3'd5, 1'b0, 32'd10);
      send_sample(3'd3, 3'd5, 1'b0, 32'd11);
   endtask

   // Largest delay across the timestamp wrap.
   task automatic test_max_delay_wrap();
      write_debounce(8'd255);
      send_sample(3'd7, 3'd0, 1'b0, 32'hFFFF_FF80);
      send_sample(3'd7, 3'd0, 1'b0, 32'h0000_007F);
      send_sample(3'd7, 3'd0, 1'b0, 32'h0000_0080);
      send_sample(3'd0, 3'd7, 1'b0, 32'hFFFF_FFFF);
      send_sample(3'd0, 3'd7, 1'b0, 32'h0000_00FF);
   endtask

   // Bouncing scans of a few hot keys under a rising clock, plus stray samples.
   task automatic test_random_scan(input int count, input int send_pct, input int recv_pct,
                                   input logic [DEB_W-1:0] delay);
      logic [5:0]        hot [4];
      logic [5:0]        k;
      logic [TIME_W-1:0] now;
      int                step_max;
      int                pick;
      write_debounce(delay);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      foreach (hot[i]) hot[i] = 6'($urandom);
      now      = $urandom;
      step_max = int'(delay) / 3 + 4;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            send_sample(3'($urandom), 3'($urandom), 1'($urandom), $urandom);
         end else begin
            k   = (pick < 20) ? 6'($urandom) : hot[$urandom_range(0, 3)];
            now = now + $urandom_range(0, step_max);
            // mostly push toward a toggle, sometimes agree with the state
            send_sample(k[5:3], k[2:0],
                        ($urandom_range(0, 99) < 75) ? key_down_q[k] : ~key_down_q[k], now);
         end
      end
   endtask

   // Check each event transfer against the oldest expectation; randomize ready.
   always @(posedge clock) begin : check_events
      key_event_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_events.size() == 0) begin
            report_mismatch($sformatf("unexpected event row %0d col %0d pressed %0d",
                                      rsp_event_row, rsp_event_col, rsp_pressed));
         end else begin
            want = expected_events.pop_front();
            if (rsp_event_row !== want.row)
               report_mismatch($sformatf("event_row %0d, want %0d", rsp_event_row, want.row));
            if (rsp_event_col !== want.col)
               report_mismatch($sformatf("event_col %0d, want %0d", rsp_event_col, want.col));
            if (rsp_pressed !== want.pressed)
               report_mismatch($sformatf("pressed %0d, want %0d", rsp_pressed, want.pressed));
         end
      end
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // End the run when no transfer happens for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      send_idle_pct = 23;
      recv_idle_pct = 61;
      apply_reset();
      test_default_delay();
      test_pending_kept();
      test_zero_delay();
      test_max_delay_wrap();
      test_random_scan(300, 23, 61, 8'($urandom));
      test_random_scan(300, 61, 23, 8'($urandom_range(0, 40)));
      test_random_scan(300, 0, 0, 8'd255);
      drain_pipeline();
      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
